// ===== src/tas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle affine setup package
// Widths, output limits and the records that pass between the pipeline parts.
// ----------------------------------------------------------------------------
package tas_pkg;

    localparam int SRC_BITS      = 12;
    localparam int DST_FRAC_BITS = 4;
    localparam int OUT_FRAC_BITS = 16;

    localparam int DST_W    = 16;
    localparam int SRC_IN_W = 12;
    localparam int OUT_W    = 48;
    localparam int N_COEF   = 6;

    localparam int OUT_SHIFT = OUT_FRAC_BITS - DST_FRAC_BITS;

    // Source products, cofactors, determinant and corner differences.
    localparam int P_W   = 2 * SRC_BITS;
    localparam int C_W   = P_W + 1;
    localparam int DET_W = C_W + 2;
    localparam int D_W   = SRC_BITS + 1;

    // Numerators: the gain terms and the wider offset terms.
    localparam int XD_W   = DST_W + D_W;
    localparam int NUMA_W = XD_W + 2;
    localparam int XC_W   = DST_W + C_W;
    localparam int NUM_W  = XC_W + 2;

    // Dividend magnitude bits after the fraction shift; one divider step per bit.
    localparam int DVW  = NUM_W + OUT_SHIFT;
    localparam int QX_W = (DVW > OUT_W + 1) ? DVW : OUT_W + 1;

    localparam int IN_BITS     = 6 * DST_W + 6 * SRC_IN_W;
    localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((N_COEF * OUT_W + 7) / 8) * 8;
    localparam int OUT_USER_W  = 2;

    localparam int USER_DEGEN = 0;
    localparam int USER_SAT   = 1;

    localparam logic [OUT_W-1:0] LIM_POS = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic [OUT_W-1:0] LIM_NEG = {1'b1, {(OUT_W - 1){1'b0}}};

    typedef struct packed {
        logic                             degen;
        logic [DET_W-1:0]                 ad;
        logic [N_COEF-1:0]                neg;
        logic [N_COEF-1:0][NUM_W-1:0]     mag;
    } t_front;

    typedef struct packed {
        logic                             degen;
        logic [N_COEF-1:0]                neg;
        logic [N_COEF-1:0][DVW-1:0]       quo;
    } t_quot;

endpackage

// ===== src/tas_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle affine setup front end
// Four stages that form the source determinant and the six Cramer numerators,
// then split them into magnitudes and result signs for the dividers.
// ----------------------------------------------------------------------------
module tas_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [tas_pkg::IN_DATA_W-1:0]  i_data,
    output logic                           o_valid,
    output tas_pkg::t_front                o_front
);
    import tas_pkg::*;

    logic signed [DST_W-1:0]  w_x [3];
    logic signed [DST_W-1:0]  w_y [3];
    logic [SRC_BITS-1:0]      w_u [3];
    logic [SRC_BITS-1:0]      w_v [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_x[k] = i_data[2 * k * DST_W +: DST_W];
            w_y[k] = i_data[(2 * k + 1) * DST_W +: DST_W];
            w_u[k] = SRC_BITS'(i_data[6 * DST_W + 2 * k * SRC_IN_W +: SRC_IN_W]);
            w_v[k] = SRC_BITS'(i_data[6 * DST_W + (2 * k + 1) * SRC_IN_W +: SRC_IN_W]);
        end
    end

    // Stage 1: source cross products and corner differences.
    logic                     r1_v;
    logic signed [DST_W-1:0]  r1_x [3];
    logic signed [DST_W-1:0]  r1_y [3];
    logic [P_W-1:0]           r1_p [6];
    logic signed [D_W-1:0]    r1_dv [3];
    logic signed [D_W-1:0]    r1_du [3];

    // Stage 2: cofactors and destination times difference products.
    logic                     r2_v;
    logic signed [DST_W-1:0]  r2_x [3];
    logic signed [DST_W-1:0]  r2_y [3];
    logic signed [C_W-1:0]    r2_c [3];
    logic signed [XD_W-1:0]   r2_xdv [3];
    logic signed [XD_W-1:0]   r2_xdu [3];
    logic signed [XD_W-1:0]   r2_ydv [3];
    logic signed [XD_W-1:0]   r2_ydu [3];

    // Stage 3: determinant, gain numerators and offset products.
    logic                     r3_v;
    logic signed [DET_W-1:0]  r3_det;
    logic signed [NUMA_W-1:0] r3_numa [4];
    logic signed [XC_W-1:0]   r3_xc [3];
    logic signed [XC_W-1:0]   r3_yc [3];

    // Stage 4: magnitudes and signs.
    logic                     r4_v;
    t_front                   r4_front;

    logic signed [NUM_W-1:0]  n_num [N_COEF];
    t_front                   n_front;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_x <= w_x;
            r1_y <= w_y;
            r1_p[0] <= P_W'(w_u[1]) * P_W'(w_v[2]);
            r1_p[1] <= P_W'(w_v[1]) * P_W'(w_u[2]);
            r1_p[2] <= P_W'(w_v[0]) * P_W'(w_u[2]);
            r1_p[3] <= P_W'(w_u[0]) * P_W'(w_v[2]);
            r1_p[4] <= P_W'(w_u[0]) * P_W'(w_v[1]);
            r1_p[5] <= P_W'(w_v[0]) * P_W'(w_u[1]);
            r1_dv[0] <= D_W'(w_v[1]) - D_W'(w_v[2]);
            r1_dv[1] <= D_W'(w_v[2]) - D_W'(w_v[0]);
            r1_dv[2] <= D_W'(w_v[0]) - D_W'(w_v[1]);
            r1_du[0] <= D_W'(w_u[2]) - D_W'(w_u[1]);
            r1_du[1] <= D_W'(w_u[0]) - D_W'(w_u[2]);
            r1_du[2] <= D_W'(w_u[1]) - D_W'(w_u[0]);

            r2_x <= r1_x;
            r2_y <= r1_y;
            for (int k = 0; k < 3; k++) begin
                r2_c[k]   <= C_W'(r1_p[2 * k]) - C_W'(r1_p[2 * k + 1]);
                r2_xdv[k] <= XD_W'(r1_x[k]) * XD_W'(r1_dv[k]);
                r2_xdu[k] <= XD_W'(r1_x[k]) * XD_W'(r1_du[k]);
                r2_ydv[k] <= XD_W'(r1_y[k]) * XD_W'(r1_dv[k]);
                r2_ydu[k] <= XD_W'(r1_y[k]) * XD_W'(r1_du[k]);
            end

            r3_det <= DET_W'(r2_c[0]) + DET_W'(r2_c[1]) + DET_W'(r2_c[2]);
            r3_numa[0] <= NUMA_W'(r2_xdv[0]) + NUMA_W'(r2_xdv[1]) + NUMA_W'(r2_xdv[2]);
            r3_numa[1] <= NUMA_W'(r2_xdu[0]) + NUMA_W'(r2_xdu[1]) + NUMA_W'(r2_xdu[2]);
            r3_numa[2] <= NUMA_W'(r2_ydv[0]) + NUMA_W'(r2_ydv[1]) + NUMA_W'(r2_ydv[2]);
            r3_numa[3] <= NUMA_W'(r2_ydu[0]) + NUMA_W'(r2_ydu[1]) + NUMA_W'(r2_ydu[2]);
            for (int k = 0; k < 3; k++) begin
                r3_xc[k] <= XC_W'(r2_x[k]) * XC_W'(r2_c[k]);
                r3_yc[k] <= XC_W'(r2_y[k]) * XC_W'(r2_c[k]);
            end

            r4_front <= n_front;
        end
    end

    always_comb begin
        n_num[0] = NUM_W'(r3_numa[0]);
        n_num[1] = NUM_W'(r3_numa[1]);
        n_num[2] = NUM_W'(r3_xc[0]) + NUM_W'(r3_xc[1]) + NUM_W'(r3_xc[2]);
        n_num[3] = NUM_W'(r3_numa[2]);
        n_num[4] = NUM_W'(r3_numa[3]);
        n_num[5] = NUM_W'(r3_yc[0]) + NUM_W'(r3_yc[1]) + NUM_W'(r3_yc[2]);

        n_front.degen = (r3_det == '0);
        n_front.ad    = r3_det[DET_W-1] ? DET_W'(-r3_det) : DET_W'(r3_det);
        for (int k = 0; k < N_COEF; k++) begin
            n_front.neg[k] = n_num[k][NUM_W-1] ^ r3_det[DET_W-1];
            n_front.mag[k] = n_num[k][NUM_W-1] ? NUM_W'(-n_num[k]) : NUM_W'(n_num[k]);
        end
    end

    assign o_valid = r4_v;
    assign o_front = r4_front;

endmodule

// ===== src/tas_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle affine setup divider array
// Six restoring dividers that share one divisor, one quotient bit per stage.
// ----------------------------------------------------------------------------
module tas_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  tas_pkg::t_front   i_front,
    output logic              o_valid,
    output tas_pkg::t_quot    o_quot
);
    import tas_pkg::*;

    logic                    r_v     [DVW];
    logic [DET_W-1:0]        r_ad    [DVW];
    logic                    r_degen [DVW];
    logic [N_COEF-1:0]       r_neg   [DVW];
    logic [DET_W-1:0]        r_rem   [DVW][N_COEF];
    logic [DVW-1:0]          r_w     [DVW][N_COEF];

    for (genvar k = 0; k < DVW; k++) begin : g_stage
        logic               v_in;
        logic [DET_W-1:0]   ad_in;
        logic               degen_in;
        logic [N_COEF-1:0]  neg_in;
        logic [DET_W-1:0]   rem_in [N_COEF];
        logic [DVW-1:0]     w_in   [N_COEF];
        logic [DET_W:0]     t      [N_COEF];
        logic [DET_W:0]     d      [N_COEF];
        logic [DET_W-1:0]   n_rem  [N_COEF];
        logic [DVW-1:0]     n_w    [N_COEF];

        if (k == 0) begin : g_first
            always_comb begin
                v_in     = i_valid;
                ad_in    = i_front.ad;
                degen_in = i_front.degen;
                neg_in   = i_front.neg;
                for (int j = 0; j < N_COEF; j++) begin
                    rem_in[j] = '0;
                    w_in[j]   = DVW'(i_front.mag[j]) << OUT_SHIFT;
                end
            end
        end else begin : g_next
            always_comb begin
                v_in     = r_v[k-1];
                ad_in    = r_ad[k-1];
                degen_in = r_degen[k-1];
                neg_in   = r_neg[k-1];
                for (int j = 0; j < N_COEF; j++) begin
                    rem_in[j] = r_rem[k-1][j];
                    w_in[j]   = r_w[k-1][j];
                end
            end
        end

        // The dividend shifts out of the top of w while quotient bits enter at the bottom.
        always_comb begin
            for (int j = 0; j < N_COEF; j++) begin
                t[j] = {rem_in[j], w_in[j][DVW-1]};
                d[j] = t[j] - {1'b0, ad_in};
                if (!d[j][DET_W]) begin
                    n_rem[j] = d[j][DET_W-1:0];
                    n_w[j]   = {w_in[j][DVW-2:0], 1'b1};
                end else begin
                    n_rem[j] = t[j][DET_W-1:0];
                    n_w[j]   = {w_in[j][DVW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ad[k]    <= ad_in;
                r_degen[k] <= degen_in;
                r_neg[k]   <= neg_in;
                for (int j = 0; j < N_COEF; j++) begin
                    r_rem[k][j] <= n_rem[j];
                    r_w[k][j]   <= n_w[j];
                end
            end
        end
    end

    always_comb begin
        o_valid      = r_v[DVW-1];
        o_quot.degen = r_degen[DVW-1];
        o_quot.neg   = r_neg[DVW-1];
        for (int j = 0; j < N_COEF; j++) begin
            o_quot.quo[j] = r_w[DVW-1][j];
        end
    end

endmodule

// ===== src/tas_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle affine setup output stage
// Clamps, applies signs, zeroes degenerate triangles and holds the result.
// ----------------------------------------------------------------------------
module tas_out (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  tas_pkg::t_quot                   i_quot,
    output logic                             o_valid,
    output logic [tas_pkg::OUT_DATA_W-1:0]   o_data,
    output logic [tas_pkg::OUT_USER_W-1:0]   o_user
);
    import tas_pkg::*;

    logic                      r_valid;
    logic [OUT_DATA_W-1:0]     r_data;
    logic [OUT_USER_W-1:0]     r_user;

    logic [QX_W-1:0]           n_q   [N_COEF];
    logic [OUT_W-1:0]          n_m   [N_COEF];
    logic [N_COEF-1:0]         n_sat;
    logic [OUT_DATA_W-1:0]     n_data;
    logic [OUT_USER_W-1:0]     n_user;

    always_comb begin
        n_data = '0;
        for (int j = 0; j < N_COEF; j++) begin
            n_q[j] = QX_W'(i_quot.quo[j]);
            if (i_quot.neg[j]) begin
                n_sat[j] = (n_q[j] > QX_W'(LIM_NEG));
                n_m[j]   = n_sat[j] ? LIM_NEG : n_q[j][OUT_W-1:0];
                n_m[j]   = -n_m[j];
            end else begin
                n_sat[j] = (n_q[j] > QX_W'(LIM_POS));
                n_m[j]   = n_sat[j] ? LIM_POS : n_q[j][OUT_W-1:0];
            end
            if (!i_quot.degen) begin
                n_data[j * OUT_W +: OUT_W] = n_m[j];
            end
        end
        n_user             = '0;
        n_user[USER_DEGEN] = i_quot.degen;
        n_user[USER_SAT]   = !i_quot.degen && (|n_sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
            r_user <= n_user;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;

endmodule

// ===== src/triangle_affine_setup.sv =====
// A request passes the front stages, the DVW divider stages and the output register;
// DVW is the numerator magnitude width plus the fraction shift, one divider stage per bit.
// Throughput: one triangle per cycle; the whole pipeline holds while a result waits.
// Reset: synchronous, active low; clears every stage valid bit and the output valid.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle affine setup
// Solves the source to destination affine map of a textured triangle by
// Cramer's rule and returns six saturated Q32.16 coefficients.
// ----------------------------------------------------------------------------
module triangle_affine_setup (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // dst_x0, dst_y0, dst_x1, dst_y1, dst_x2, dst_y2, src_u0, src_v0, src_u1,
    // src_v1, src_u2, src_v2
    input  logic [tas_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // coef_xu, coef_xv, offset_x, coef_yu, coef_yv, offset_y
    output logic [tas_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // degenerate, saturated
    output logic [tas_pkg::OUT_USER_W-1:0]   m_axis_tuser
);
    import tas_pkg::*;

    logic    w_en;
    logic    w_front_v;
    t_front  w_front;
    logic    w_div_v;
    t_quot   w_quot;

    assign w_en          = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    tas_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .o_valid (w_front_v),
        .o_front (w_front)
    );

    tas_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_front_v),
        .i_front (w_front),
        .o_valid (w_div_v),
        .o_quot  (w_quot)
    );

    tas_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_v),
        .i_quot  (w_quot),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata),
        .o_user  (m_axis_tuser)
    );

`ifndef ASSERT_OFF
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[USER_DEGEN]
        |-> !m_axis_tuser[USER_SAT] && (m_axis_tdata == '0))
        else $error("degenerate result with nonzero coefficients or saturation");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_front_v) && $stable(w_div_v))
        else $error("pipeline valid bits moved during a stall");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !w_front_v && !w_div_v)
        else $error("valid bits not cleared by reset");
`endif

endmodule

// ===== sim/triangle_affine_setup_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle affine setup testbench
// Streams directed and random triangles into the setup unit, solves each
// triangle again with exact integer arithmetic, and compares every result
// field with the prediction while both stream sides stall at random.
// ----------------------------------------------------------------------------
module triangle_affine_setup_test;
    import tas_pkg::*;

    typedef struct packed {
        logic [2:0][SRC_IN_W-1:0] v;
        logic [2:0][SRC_IN_W-1:0] u;
        logic [2:0][DST_W-1:0]    y;
        logic [2:0][DST_W-1:0]    x;
    } tri_t;

    typedef struct packed {
        logic [N_COEF-1:0][OUT_W-1:0] coef;
        logic                         degen;
        logic                         sat;
    } affine_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    string   coef_names [N_COEF] = '{"coef_xu", "coef_xv", "offset_x",
                                     "coef_yu", "coef_yv", "offset_y"};

    tri_t    pending_tris[$];
    affine_t expected_maps[$];
    tri_t    cur_tri;
    int      send_gap;
    int      recv_gap;
    int      n_sent;
    int      n_recv;
    int      n_degen;
    int      n_sat;
    int      n_fail;
    bit      long_hold_done;

    triangle_affine_setup dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Quotient of num * 2^OUT_SHIFT by den, truncated toward zero and clamped.
    function automatic logic [OUT_W-1:0] scaled_quotient(input longint num, input longint den,
                                                         inout logic sat);
        logic [63:0] an, ad, q, r, m;
        logic        neg;
        an  = (num < 0) ? 64'(-num) : 64'(num);
        ad  = (den < 0) ? 64'(-den) : 64'(den);
        neg = (num < 0) != (den < 0);
        q   = an / ad;
        r   = an % ad;
        if (q > (64'(LIM_NEG) >> OUT_SHIFT))
            m = 64'(LIM_NEG) + 64'd1;
        else
            m = (q << OUT_SHIFT) + ((r << OUT_SHIFT) / ad);
        if (neg) begin
            if (m > 64'(LIM_NEG)) begin
                m   = 64'(LIM_NEG);
                sat = 1'b1;
            end
            return OUT_W'(64'd0 - m);
        end
        if (m > 64'(LIM_POS)) begin
            m   = 64'(LIM_POS);
            sat = 1'b1;
        end
        return OUT_W'(m);
    endfunction

    function automatic affine_t solve_affine(input tri_t t);
        longint  x[3], y[3], u[3], v[3], cof[3], num[N_COEF], det;
        affine_t a;
        for (int i = 0; i < 3; i++) begin
            x[i] = longint'($signed(t.x[i]));
            y[i] = longint'($signed(t.y[i]));
            u[i] = longint'(t.u[i][SRC_BITS-1:0]);
            v[i] = longint'(t.v[i][SRC_BITS-1:0]);
        end
        cof[0] = u[1] * v[2] - v[1] * u[2];
        cof[1] = v[0] * u[2] - u[0] * v[2];
        cof[2] = u[0] * v[1] - v[0] * u[1];
        det    = cof[0] + cof[1] + cof[2];
        a      = '0;
        if (det == 0) begin
            a.degen = 1'b1;
            return a;
        end
        num[0] = x[0] * (v[1] - v[2]) + x[1] * (v[2] - v[0]) + x[2] * (v[0] - v[1]);
        num[1] = x[0] * (u[2] - u[1]) + x[1] * (u[0] - u[2]) + x[2] * (u[1] - u[0]);
        num[2] = x[0] * cof[0] + x[1] * cof[1] + x[2] * cof[2];
        num[3] = y[0] * (v[1] - v[2]) + y[1] * (v[2] - v[0]) + y[2] * (v[0] - v[1]);
        num[4] = y[0] * (u[2] - u[1]) + y[1] * (u[0] - u[2]) + y[2] * (u[1] - u[0]);
        num[5] = y[0] * cof[0] + y[1] * cof[1] + y[2] * cof[2];
        for (int k = 0; k < N_COEF; k++)
            a.coef[k] = scaled_quotient(num[k], det, a.sat);
        return a;
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_tri(input tri_t t);
        logic [IN_DATA_W-1:0] d;
        d = '0;
        for (int i = 0; i < 3; i++) begin
            d[i*2*DST_W +: DST_W]                              = t.x[i];
            d[i*2*DST_W + DST_W +: DST_W]                      = t.y[i];
            d[6*DST_W + i*2*SRC_IN_W +: SRC_IN_W]              = t.u[i];
            d[6*DST_W + i*2*SRC_IN_W + SRC_IN_W +: SRC_IN_W]   = t.v[i];
        end
        return d;
    endfunction

    task automatic queue_tri(input int x0, y0, x1, y1, x2, y2, u0, v0, u1, v1, u2, v2);
        tri_t t;
        t.x = {DST_W'(x2), DST_W'(x1), DST_W'(x0)};
        t.y = {DST_W'(y2), DST_W'(y1), DST_W'(y0)};
        t.u = {SRC_IN_W'(u2), SRC_IN_W'(u1), SRC_IN_W'(u0)};
        t.v = {SRC_IN_W'(v2), SRC_IN_W'(v1), SRC_IN_W'(v0)};
        pending_tris.push_back(t);
    endtask

    // Gaps vanish in every third block of a hundred requests.
    function automatic int draw_gap(input int count);
        if ((count / 100) % 3 == 1)
            return 0;
        return $urandom_range(0, 9);
    endfunction

    // Driver: one request per handshake, a random gap before the next.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_maps.push_back(solve_affine(cur_tri));
                n_sent <= n_sent + 1;
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                s_axis_tvalid <= 1'b1;
            end else if (send_gap > 0) begin
                send_gap      <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_tris.size() > 0) begin
                cur_tri = pending_tris.pop_front();
                s_axis_tdata  <= pack_tri(cur_tri);
                s_axis_tvalid <= 1'b1;
                send_gap      <= draw_gap(n_sent);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result and paces the ready line.
    always @(posedge i_clk) begin
        affine_t exp_map;
        int      gap_draw;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_gap      <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_maps.size() == 0) begin
                    $error("result with no request outstanding");
                    n_fail++;
                end else begin
                    exp_map = expected_maps.pop_front();
                    for (int k = 0; k < N_COEF; k++) begin
                        if (m_axis_tdata[k*OUT_W +: OUT_W] !== exp_map.coef[k]) begin
                            $error("%s: expected %0d, got %0d", coef_names[k],
                                   $signed(exp_map.coef[k]),
                                   $signed(m_axis_tdata[k*OUT_W +: OUT_W]));
                            n_fail++;
                        end
                    end
                    if (m_axis_tuser[USER_DEGEN] !== exp_map.degen) begin
                        $error("degenerate: expected %0b, got %0b", exp_map.degen,
                               m_axis_tuser[USER_DEGEN]);
                        n_fail++;
                    end
                    if (m_axis_tuser[USER_SAT] !== exp_map.sat) begin
                        $error("saturated: expected %0b, got %0b", exp_map.sat,
                               m_axis_tuser[USER_SAT]);
                        n_fail++;
                    end
                    n_degen += exp_map.degen;
                    n_sat   += exp_map.sat;
                end
                n_recv++;
                // One long hold-off lets the pipeline fill and push back on the sender.
                if (n_recv == 300 && !long_hold_done) begin
                    long_hold_done = 1'b1;
                    recv_gap      <= 300;
                    m_axis_tready <= 1'b0;
                end else begin
                    gap_draw       = draw_gap(n_recv);
                    recv_gap      <= gap_draw;
                    m_axis_tready <= (gap_draw == 0);
                end
            end else if (recv_gap > 0) begin
                recv_gap      <= recv_gap - 1;
                m_axis_tready <= (recv_gap == 1);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int bu, bv;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        n_sent = 0;
        n_recv = 0;
        n_degen = 0;
        n_sat = 0;
        n_fail = 0;
        long_hold_done = 1'b0;

        // Directed: a unit triangle, field extremes, collinear and clipping cases.
        queue_tri(0, 0, 16, 0, 0, 16, 0, 0, 1, 0, 0, 1);
        queue_tri(-32768, 32767, 32767, -32768, 0, 0, 0, 0, 4095, 0, 0, 4095);
        queue_tri(32767, 32767, 32767, 32767, 32767, 32767, 0, 0, 4095, 0, 0, 4095);
        queue_tri(-32768, -32768, -32768, -32768, -32768, -32768, 4095, 4095, 0, 4095, 4095, 0);
        queue_tri(-32768, 32767, 32767, -32768, -32768, 32767, 0, 0, 1, 0, 0, 1);
        queue_tri(100, 200, 300, 400, 500, 600, 0, 0, 1, 1, 2, 2);
        queue_tri(5, 6, 7, 8, 9, 10, 4095, 4095, 4095, 4095, 4095, 4095);
        queue_tri(1, 2, 3, 4, 5, 6, 0, 0, 0, 0, 0, 0);
        queue_tri(10, 20, 30, 40, 50, 60, 7, 3, 7, 9, 7, 4000);
        queue_tri(32767, -32768, -32768, 32767, 32767, -32768,
                  4095, 4094, 4094, 4093, 4093, 4093);
        queue_tri(-32768, 32767, 32767, -32768, -32768, -32768,
                  4095, 4094, 4094, 4093, 4093, 4093);
        queue_tri(32767, 32767, -32768, -32768, 0, 0, 4095, 4095, 4094, 4094, 4095, 4094);
        queue_tri(-1, -1, 1, 1, -1, 1, 2048, 2048, 2049, 2048, 2048, 2049);
        queue_tri(-32768, -32768, 32767, 32767, 32767, -32768,
                  4095, 0, 0, 4095, 4094, 1);
        queue_tri(16, 0, 0, 16, 0, 0, 4095, 0, 0, 4095, 0, 0);
        queue_tri(-16, -16, 16, 16, 16, -16, 3, 3, 4095, 4095, 4095, 3);

        for (int n = 0; n < 900; n++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: queue_tri($urandom, $urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom);
                4, 5, 6: begin
                    // Nearly collinear corners far from the origin: big offsets, clipping.
                    bu = $urandom_range(0, 4095);
                    bv = $urandom_range(0, 4095);
                    queue_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              bu, bv, (bu + $urandom_range(0, 3)) % 4096,
                              (bv + $urandom_range(0, 3)) % 4096,
                              (bu + $urandom_range(0, 3)) % 4096,
                              (bv + $urandom_range(0, 3)) % 4096);
                end
                7: begin
                    bu = $urandom_range(0, 1365);
                    bv = $urandom_range(0, 1365);
                    queue_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              0, 0, bu, bv, 2 * bu, 2 * bv);
                end
                default: queue_tri($urandom_range(0, 4095), $urandom_range(0, 4095),
                                   $urandom_range(0, 4095), $urandom_range(0, 4095),
                                   $urandom_range(0, 4095), $urandom_range(0, 4095),
                                   $urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(0, 255), $urandom_range(0, 255));
            endcase
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_tris.size() == 0 && !s_axis_tvalid && expected_maps.size() == 0);
        repeat (80) @(posedge i_clk);
        $display("Checked %0d triangles, %0d degenerate and %0d with clipped coefficients.",
                 n_recv, n_degen, n_sat);
        $display("Both stream sides stalled at random, with one long output hold-off.");
        if (n_fail == 0 && expected_maps.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== triangle_affine_setup.f =====
src/tas_pkg.sv
src/tas_front.sv
src/tas_div.sv
src/tas_out.sv
src/triangle_affine_setup.sv
sim/triangle_affine_setup_test.sv
